### rtl/core/ptif_pkg.sv
// ----------------------------------------------------------------------------
// ptif_pkg
// Shared constants and helpers for the packet truncation unit with IPv4
// header length and checksum fixup.
// ----------------------------------------------------------------------------
package ptif_pkg;

  // Default depth of the IPv4 header hold buffer in bytes.
  localparam int unsigned HEADER_HOLD_BYTES = 60;

  // Configuration register indexes.
  localparam logic REG_ENABLE    = 1'b0;
  localparam logic REG_TRUNC_LEN = 1'b1;

  // Ethernet framing.
  localparam logic [4:0]  ETH_BASE_LEN = 5'd14;
  localparam logic [4:0]  TAG_LEN      = 5'd4;
  localparam logic [4:0]  TAGGED_IP_OFF = ETH_BASE_LEN + TAG_LEN;
  localparam logic [15:0] TYPE_IPV4    = 16'h0800;
  localparam logic [15:0] TYPE_CTAG    = 16'h8100;
  localparam logic [15:0] TYPE_STAG    = 16'h88A8;

  // Byte positions of the outer and inner type fields.
  localparam logic [15:0] POS_TYPE_HI  = 16'd12;
  localparam logic [15:0] POS_TYPE_LO  = 16'd13;
  localparam logic [15:0] POS_INNER_HI = 16'd16;
  localparam logic [15:0] POS_INNER_LO = 16'd17;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;

  // IPv4 header layout.
  localparam logic [3:0] IPV4_VERSION = 4'h4;
  localparam logic [5:0] IPV4_MIN_HDR = 6'd20;
  localparam logic [5:0] OFF_TLEN_HI  = 6'd2;
  localparam logic [5:0] OFF_TLEN_LO  = 6'd3;
  localparam logic [5:0] OFF_CSUM_HI  = 6'd10;
  localparam logic [5:0] OFF_CSUM_LO  = 6'd11;

  // Smallest kept lengths that still hold a minimal IPv4 header, or for VLAN the tag.
  localparam logic [15:0] KEEP_MIN_UNTAGGED = 16'(ETH_BASE_LEN) + 16'(IPV4_MIN_HDR);
  localparam logic [15:0] KEEP_MIN_VLAN     = 16'(ETH_BASE_LEN) + 16'(TAG_LEN);
  localparam logic [15:0] KEEP_MIN_TAGGED   = 16'(TAGGED_IP_OFF) + 16'(IPV4_MIN_HDR);

  // Adds one header byte to the running ones'-complement sum. The total
  // length and checksum fields are left out since both get rewritten.
  function automatic logic [20:0] csum_add(logic [20:0] sum, logic [5:0] off,
                                           logic [7:0] b);
    logic [20:0] addend;
    addend = off[0] ? {13'd0, b} : {5'd0, b, 8'd0};
    if (off == OFF_TLEN_HI || off == OFF_TLEN_LO ||
        off == OFF_CSUM_HI || off == OFF_CSUM_LO) begin
      return sum;
    end
    return sum + addend;
  endfunction

endpackage

### rtl/core/packet_truncate_ipv4_fixup_unit.sv
// ----------------------------------------------------------------------------
// packet_truncate_ipv4_fixup_unit
// Truncates byte-wide frames to a configured length and, for IPv4 frames,
// holds the IPv4 header to rewrite its total length and header checksum.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] data_byte, tdata[23:8] frame_length,
//                      tlast last_in
// m_axis    out        tdata[7:0] out_byte, tlast out_last
// cfg       in         index 0 enable, index 1 truncate_length
//
// Bytes that pass through go out through the output register, one beat per
// cycle while the output is not stalled. A held IPv4 header stalls the input
// from the beat after its last byte while the header memory is read back, one
// read per cycle through its single read port when the output is free.
// Reset clears all control state; the header memory needs no clearing.
// Stalls on the output side hold the input off only once the output
// register is full.
// ----------------------------------------------------------------------------
module packet_truncate_ipv4_fixup_unit #(
  parameter int unsigned HEADER_HOLD_BYTES = ptif_pkg::HEADER_HOLD_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] frame_length
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast
);
  import ptif_pkg::*;

  localparam int unsigned IDX_W = $clog2(HEADER_HOLD_BYTES);
  localparam int unsigned CNT_W = $clog2(HEADER_HOLD_BYTES + 1);
  localparam logic [6:0]  HOLD_MAX = 7'(HEADER_HOLD_BYTES);

  // Configuration.
  logic        en_q;
  logic [15:0] tlen_q;

  // Frame parse state.
  logic [15:0] pos_q, pos_d;
  logic        cut_q, cut_d;
  logic [15:0] kept_q, kept_d;
  logic [15:0] eth_q, eth_d;
  logic        vlan_q, vlan_d;
  logic [4:0]  ipoff_q, ipoff_d;
  logic [5:0]  need_q, need_d;
  logic        hold_q, hold_d;
  logic [CNT_W-1:0] hold_cnt_q, hold_cnt_d;
  logic [20:0] csum_q, csum_d;
  logic [15:0] total_q, total_d;
  logic [21:0] s1_q;
  logic [15:0] chk_q;

  // Release sequencer.
  logic             rel_active_q, rel_active_d;
  logic             rel_fixed_q, rel_fixed_d;
  logic             rel_mark_q, rel_mark_d;
  logic [CNT_W-1:0] rel_cnt_q, rel_cnt_d;
  logic [IDX_W-1:0] iss_q, iss_d;
  logic             rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;

  // Header memory.
  logic [7:0]       hdr_mem [HEADER_HOLD_BYTES];
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  logic [7:0]       rd_data_q;

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_load;

  logic       in_acc, out_free, move;
  logic [7:0] b;
  logic [15:0] flen;
  logic        last;

  // Frame-start view of the state.
  logic        first;
  logic        cut_e;
  logic [15:0] kept_e, eth_e, eth_v;
  logic        vlan_e, hold_e;
  logic [4:0]  ipoff_e;
  logic [20:0] csum_e;
  logic [5:0]  ihl;
  logic        ihl_ok;
  logic        pos_end;

  logic [16:0] fold1;
  logic [15:0] fold2;

  assign b    = s_axis_tdata[7:0];
  assign flen = s_axis_tdata[23:8];
  assign last = s_axis_tlast;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !rel_active_q && !rd_pend_q && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign move          = rd_pend_q && out_free;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      tlen_q <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE:    en_q   <= cfg_wdata_i[0];
        REG_TRUNC_LEN: tlen_q <= cfg_wdata_i;
        default:       en_q   <= en_q;
      endcase
    end
  end

  always_comb begin
    first   = (pos_q == 16'd0);
    cut_e   = first ? (en_q && tlen_q != 16'd0 && flen > tlen_q) : cut_q;
    kept_e  = first ? tlen_q : kept_q;
    eth_e   = first ? 16'd0 : eth_q;
    vlan_e  = first ? 1'b0 : vlan_q;
    ipoff_e = first ? 5'd0 : ipoff_q;
    hold_e  = first ? 1'b0 : hold_q;
    csum_e  = first ? 21'd0 : csum_q;
    ihl     = {b[3:0], 2'b00};
    ihl_ok  = b[7:4] == IPV4_VERSION && ihl >= IPV4_MIN_HDR &&
              {1'b0, ihl} <= HOLD_MAX &&
              {1'b0, kept_e} >= 17'(ipoff_e) + 17'(ihl);
    pos_end = ({1'b0, pos_q} + 17'd1) == {1'b0, kept_e};
    eth_v   = eth_e | {8'd0, b};

    pos_d      = pos_q;
    cut_d      = cut_q;
    kept_d     = kept_q;
    eth_d      = eth_q;
    vlan_d     = vlan_q;
    ipoff_d    = ipoff_q;
    need_d     = need_q;
    hold_d     = hold_q;
    hold_cnt_d = hold_cnt_q;
    csum_d     = csum_q;
    total_d    = total_q;

    rel_active_d = rel_active_q;
    rel_fixed_d  = rel_fixed_q;
    rel_mark_d   = rel_mark_q;
    rel_cnt_d    = rel_cnt_q;
    iss_d        = iss_q;
    rd_pend_d    = rd_pend_q;
    rd_idx_d     = rd_idx_q;
    rd_en        = 1'b0;

    wr_en   = 1'b0;
    wr_addr = '0;

    out_load   = 1'b0;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;

    if (in_acc) begin
      cut_d   = cut_e;
      kept_d  = kept_e;
      eth_d   = eth_e;
      vlan_d  = vlan_e;
      ipoff_d = ipoff_e;
      hold_d  = hold_e;
      csum_d  = csum_e;

      if (cut_e && pos_q >= kept_e) begin
        // Past the kept length: the beat is dropped.
      end else if (hold_e) begin
        wr_en   = 1'b1;
        wr_addr = hold_cnt_q[IDX_W-1:0];
        csum_d  = csum_add(csum_e, 6'(hold_cnt_q), b);
        if (6'(hold_cnt_q) + 6'd1 == need_q) begin
          rel_active_d = 1'b1;
          rel_fixed_d  = 1'b1;
          rel_mark_d   = last || pos_end;
          rel_cnt_d    = hold_cnt_q + CNT_W'(1);
          iss_d        = '0;
          total_d      = kept_e - 16'(ipoff_e);
          hold_d       = 1'b0;
          ipoff_d      = 5'd0;
        end else if (last) begin
          // Frame ended inside the header: release it as it came.
          rel_active_d = 1'b1;
          rel_fixed_d  = 1'b0;
          rel_mark_d   = 1'b1;
          rel_cnt_d    = hold_cnt_q + CNT_W'(1);
          iss_d        = '0;
          hold_d       = 1'b0;
        end else begin
          hold_cnt_d = hold_cnt_q + CNT_W'(1);
        end
      end else if (cut_e && ipoff_e != 5'd0 && pos_q == 16'(ipoff_e)) begin
        if (ihl_ok) begin
          hold_d     = 1'b1;
          need_d     = ihl;
          wr_en      = 1'b1;
          wr_addr    = '0;
          csum_d     = {5'd0, b, 8'd0};
          hold_cnt_d = CNT_W'(1);
          if (last) begin
            rel_active_d = 1'b1;
            rel_fixed_d  = 1'b0;
            rel_mark_d   = 1'b1;
            rel_cnt_d    = CNT_W'(1);
            iss_d        = '0;
            hold_d       = 1'b0;
          end
        end else begin
          ipoff_d    = 5'd0;
          out_load   = 1'b1;
          out_byte_d = b;
          out_last_d = last || pos_end;
        end
      end else begin
        if (cut_e) begin
          if (pos_q == POS_TYPE_HI || pos_q == POS_INNER_HI) begin
            eth_d = {b, 8'd0};
          end else if (pos_q == POS_TYPE_LO) begin
            eth_d = eth_v;
            if (eth_v == TYPE_IPV4 && kept_e >= KEEP_MIN_UNTAGGED) begin
              ipoff_d = ETH_BASE_LEN;
            end else if ((eth_v == TYPE_CTAG || eth_v == TYPE_STAG) &&
                         kept_e >= KEEP_MIN_VLAN) begin
              vlan_d = 1'b1;
            end
          end else if (pos_q == POS_INNER_LO && vlan_e) begin
            eth_d  = eth_v;
            vlan_d = 1'b0;
            if (eth_v == TYPE_IPV4 && kept_e >= KEEP_MIN_TAGGED) begin
              ipoff_d = TAGGED_IP_OFF;
            end
          end
        end
        out_load   = 1'b1;
        out_byte_d = b;
        out_last_d = last || (cut_e && pos_end);
      end

      if (last) begin
        pos_d  = 16'd0;
        hold_d = 1'b0;
      end else if (pos_q != POS_MAX) begin
        pos_d = pos_q + 16'd1;
      end
    end

    // Read back the held header, one memory read per cycle while the output
    // register is free. The read data register keeps its byte until the output register takes it.
    if (move) begin
      out_load   = 1'b1;
      out_byte_d = rd_data_q;
      if (rel_fixed_q) begin
        case (6'(rd_idx_q))
          OFF_TLEN_HI: out_byte_d = total_q[15:8];
          OFF_TLEN_LO: out_byte_d = total_q[7:0];
          OFF_CSUM_HI: out_byte_d = chk_q[15:8];
          OFF_CSUM_LO: out_byte_d = chk_q[7:0];
          default:     out_byte_d = rd_data_q;
        endcase
      end
      out_last_d = rel_mark_q && (CNT_W'(rd_idx_q) + CNT_W'(1) == rel_cnt_q);
      rd_pend_d  = 1'b0;
    end
    if (rel_active_q && (!rd_pend_q || move)) begin
      rd_en     = 1'b1;
      rd_pend_d = 1'b1;
      rd_idx_d  = iss_q;
      if (CNT_W'(iss_q) + CNT_W'(1) == rel_cnt_q) begin
        rel_active_d = 1'b0;
      end else begin
        iss_d = iss_q + IDX_W'(1);
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    // The checksum passes through the sum register s1_q and then the folded complement
    // register chk_q after the header's last byte, well before its bytes are read back.
    fold1 = {1'b0, s1_q[15:0]} + {11'd0, s1_q[21:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= 16'd0;
      cut_q        <= 1'b0;
      kept_q       <= 16'd0;
      eth_q        <= 16'd0;
      vlan_q       <= 1'b0;
      ipoff_q      <= 5'd0;
      need_q       <= 6'd0;
      hold_q       <= 1'b0;
      hold_cnt_q   <= '0;
      csum_q       <= 21'd0;
      rel_active_q <= 1'b0;
      rel_fixed_q  <= 1'b0;
      rel_mark_q   <= 1'b0;
      rel_cnt_q    <= '0;
      iss_q        <= '0;
      rd_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      cut_q        <= cut_d;
      kept_q       <= kept_d;
      eth_q        <= eth_d;
      vlan_q       <= vlan_d;
      ipoff_q      <= ipoff_d;
      need_q       <= need_d;
      hold_q       <= hold_d;
      hold_cnt_q   <= hold_cnt_d;
      csum_q       <= csum_d;
      rel_active_q <= rel_active_d;
      rel_fixed_q  <= rel_fixed_d;
      rel_mark_q   <= rel_mark_d;
      rel_cnt_q    <= rel_cnt_d;
      iss_q        <= iss_d;
      rd_pend_q    <= rd_pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    total_q    <= total_d;
    s1_q       <= {1'b0, csum_q} + {6'd0, total_q};
    chk_q      <= ~fold2;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hdr_mem[wr_addr] <= b;
    end
    if (rd_en) begin
      rd_data_q <= hdr_mem[iss_q];
    end
  end

endmodule

### sim/ptif_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptif_stream_checker
// Watches the configuration port and both byte streams of the truncation
// unit. It works out, for every accepted input beat, the output beats that
// the unit owes, and compares them in order with the beats that leave it.
// ----------------------------------------------------------------------------
module ptif_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] frame_length
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  input  logic        m_axis_tlast,
  output int unsigned mismatch_count_o,
  output int unsigned beats_owed_o
);
  import ptif_pkg::*;

  localparam int unsigned HoldBytes = HEADER_HOLD_BYTES;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  out_beat_t   owed_q[$];

  // Register copies.
  logic        cut_en;
  logic [15:0] cut_len;

  // Per-frame state.
  logic [15:0] pos;
  logic        cutting;
  logic [15:0] keep_len;
  logic [15:0] type_acc;
  logic        tag_seen;
  logic [4:0]  ip_off;
  logic [5:0]  ip_len;
  logic        holding;
  logic [20:0] hdr_sum;
  logic [7:0]  hdr_mem [HoldBytes];

  // The total length and checksum words are left out of the sum since both
  // get rewritten.
  function automatic logic [20:0] sum_byte(logic [20:0] acc, int unsigned off,
                                           logic [7:0] b);
    if (off == OFF_TLEN_HI || off == OFF_TLEN_LO ||
        off == OFF_CSUM_HI || off == OFF_CSUM_LO) begin
      return acc;
    end
    return acc + ((off % 2 == 1) ? 21'(b) : 21'({b, 8'h00}));
  endfunction

  task automatic flush_header(int unsigned count, bit fixed, bit mark);
    logic [15:0] tot;
    logic [31:0] fold;
    logic [15:0] csum;
    if (count > HoldBytes) count = HoldBytes;
    if (fixed && count >= 12) begin
      tot  = keep_len - 16'(ip_off);
      fold = 32'(hdr_sum) + 32'(tot);
      fold = (fold & 32'hFFFF) + (fold >> 16);
      fold = (fold & 32'hFFFF) + (fold >> 16);
      csum = ~fold[15:0];
      hdr_mem[2]  = tot[15:8];
      hdr_mem[3]  = tot[7:0];
      hdr_mem[10] = csum[15:8];
      hdr_mem[11] = csum[7:0];
    end
    for (int i = 0; i < count; i++) begin
      owed_q.push_back(out_beat_t'{data: hdr_mem[i], last: mark && (i + 1 == count)});
    end
  endtask

  task automatic absorb_beat(logic [7:0] b, logic [15:0] flen, logic last);
    logic [15:0] p;
    int unsigned off;
    int unsigned ihl;
    bit          started;
    p       = pos;
    started = 1'b0;

    if (p == 0) begin
      cutting  = cut_en && cut_len != 0 && flen > cut_len;
      keep_len = cut_len;
      type_acc = '0;
      tag_seen = 1'b0;
      ip_off   = '0;
      ip_len   = '0;
      holding  = 1'b0;
      hdr_sum  = '0;
    end

    if (cutting && p >= keep_len) begin
      // Past the kept length: the beat is dropped.
    end else if (holding) begin
      off = p - ip_off;
      if (off < ip_len && off < HoldBytes) begin
        hdr_mem[off] = b;
        hdr_sum      = sum_byte(hdr_sum, off, b);
        if (off + 1 == ip_len) begin
          flush_header(off + 1, 1'b1, last || (32'(p) + 1 == 32'(keep_len)));
          holding = 1'b0;
          ip_off  = '0;
        end else if (last) begin
          // The frame ended inside the header, so it goes out untouched.
          flush_header(off + 1, 1'b0, 1'b1);
          holding = 1'b0;
        end
      end else begin
        holding = 1'b0;
        owed_q.push_back(out_beat_t'{data: b, last: last});
      end
    end else begin
      if (cutting) begin
        if (ip_off != 0 && p == ip_off) begin
          ihl = 32'(b[3:0]) * 4;
          if (b[7:4] == IPV4_VERSION && ihl >= IPV4_MIN_HDR && ihl <= HoldBytes &&
              32'(keep_len) >= 32'(ip_off) + ihl) begin
            started    = 1'b1;
            holding    = 1'b1;
            ip_len     = ihl[5:0];
            hdr_sum    = '0;
            hdr_mem[0] = b;
            hdr_sum    = sum_byte(hdr_sum, 0, b);
          end else begin
            ip_off = '0;
          end
        end else if (p == POS_TYPE_HI || p == POS_INNER_HI) begin
          type_acc = {b, 8'h00};
        end else if (p == POS_TYPE_LO) begin
          type_acc = type_acc | {8'h00, b};
          if (type_acc == TYPE_IPV4 && keep_len >= KEEP_MIN_UNTAGGED) begin
            ip_off = ETH_BASE_LEN;
          end else if ((type_acc == TYPE_CTAG || type_acc == TYPE_STAG) &&
                       keep_len >= KEEP_MIN_VLAN) begin
            tag_seen = 1'b1;
          end
        end else if (p == POS_INNER_LO && tag_seen) begin
          type_acc = type_acc | {8'h00, b};
          tag_seen = 1'b0;
          if (type_acc == TYPE_IPV4 && keep_len >= KEEP_MIN_TAGGED) begin
            ip_off = TAGGED_IP_OFF;
          end
        end
      end
      if (started) begin
        if (last) begin
          flush_header(1, 1'b0, 1'b1);
          holding = 1'b0;
        end
      end else begin
        owed_q.push_back(out_beat_t'{data: b,
            last: last || (cutting && 32'(p) + 1 == 32'(keep_len))});
      end
    end

    if (last) begin
      pos     = '0;
      holding = 1'b0;
    end else if (p != POS_MAX) begin
      pos = p + 16'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      owed_q.delete();
      cut_en           = 1'b0;
      cut_len          = '0;
      pos              = '0;
      cutting          = 1'b0;
      keep_len         = '0;
      type_acc         = '0;
      tag_seen         = 1'b0;
      ip_off           = '0;
      ip_len           = '0;
      holding          = 1'b0;
      hdr_sum          = '0;
      mismatch_count_o = 0;
      beats_owed_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ENABLE) begin
          cut_en = cfg_wdata_i[0];
        end else begin
          cut_len = cfg_wdata_i;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_beat(s_axis_tdata[7:0], s_axis_tdata[23:8], s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_q.size() == 0) begin
          $error("out_byte: expected no beat, got %02h", m_axis_tdata);
          mismatch_count_o++;
        end else begin
          want = owed_q.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata);
            mismatch_count_o++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, m_axis_tlast);
            mismatch_count_o++;
          end
        end
      end
      beats_owed_o <= owed_q.size();
    end
  end

endmodule

### sim/tb_packet_truncate_ipv4_fixup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_truncate_ipv4_fixup_unit
// Drives byte frames into the truncation unit under a range of register
// settings: plain, VLAN-tagged and malformed IPv4 frames and frames that end
// early, then random frames until the beat budget is used up.
// Both stream sides idle in random bursts; the checker judges every beat.
// ----------------------------------------------------------------------------
module tb_packet_truncate_ipv4_fixup_unit;
  import ptif_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned ItemBudget = 430;
  localparam int unsigned SettleWait = 100;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [7:0] data_byte, [23:8] frame_length
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] out_byte
  logic        m_axis_tlast;

  int unsigned mismatches;
  int unsigned beats_owed;

  bit          gaps_on     = 1'b0;
  bit          stalls_on   = 1'b0;
  int unsigned squeeze_req = 0;
  int unsigned sent_beats  = 0;

  packet_truncate_ipv4_fixup_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  ptif_stream_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .mismatch_count_o (mismatches),
    .beats_owed_o     (beats_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Output side. A squeeze request holds tready low long enough for the unit
  // to fill up and push back on its input.
  initial begin
    int unsigned idle_left;
    int unsigned hold_left;
    int unsigned squeeze_done;
    idle_left    = 0;
    hold_left    = 0;
    squeeze_done = 0;
    forever begin
      @(posedge clk_i);
      if (squeeze_req != squeeze_done) begin
        squeeze_done = squeeze_req;
        hold_left    = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        m_axis_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic [15:0] flen, input logic last);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {flen, b};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_beats++;
  endtask

  // Builds a frame of nbytes bytes (addresses, type, optional tag, first IP
  // byte, random rest) and sends it with flen as its stated length.
  task automatic send_frame(input logic [15:0] outer, input logic [15:0] inner,
                            input logic [7:0] ver_ihl, input int unsigned nbytes,
                            input logic [15:0] flen);
    logic [7:0] wire_q[$];
    repeat (12) wire_q.push_back(8'($urandom));
    wire_q.push_back(outer[15:8]);
    wire_q.push_back(outer[7:0]);
    if (outer == TYPE_CTAG || outer == TYPE_STAG) begin
      wire_q.push_back(8'($urandom));
      wire_q.push_back(8'($urandom));
      wire_q.push_back(inner[15:8]);
      wire_q.push_back(inner[7:0]);
    end
    wire_q.push_back(ver_ihl);
    while (wire_q.size() < nbytes) wire_q.push_back(8'($urandom));
    while (wire_q.size() > nbytes) void'(wire_q.pop_back());
    foreach (wire_q[i]) push_byte(wire_q[i], flen, i == wire_q.size() - 1);
  endtask

  // Lets every owed beat drain, then waits out a possible header release.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (beats_owed != 0);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic set_config(input logic en, input logic [15:0] len);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_ENABLE;
    cfg_wdata_i <= {15'd0, en};
    @(posedge clk_i);
    cfg_idx_i   <= REG_TRUNC_LEN;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned kind;
    int unsigned ihl;
    int unsigned ip_at;
    int unsigned nbytes;
    int unsigned hdr_end;
    logic [15:0] outer;
    logic [15:0] inner;
    logic [15:0] flen;
    logic [15:0] keep;
    logic [7:0]  ver_ihl;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at reset values: everything passes, first under a long stall.
    squeeze_req++;
    send_frame(TYPE_IPV4, '0, 8'h45, 24, 24);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_frame(16'h0000, '0, 8'h00, 1, 1);

    wait_quiet();
    set_config(1'b1, 16'd0);
    send_frame(TYPE_IPV4, '0, 8'h45, 12, 12);
    wait_quiet();
    set_config(1'b1, 16'hFFFF);
    send_frame(TYPE_IPV4, '0, 8'h45, 12, 16'hFFFF);
    wait_quiet();
    set_config(1'b0, 16'd8);
    send_frame(TYPE_IPV4, '0, 8'h45, 12, 12);

    // Short frames with a long stated length reach the header check quickly.
    wait_quiet();
    set_config(1'b1, 16'd38);
    send_frame(TYPE_IPV4, '0, 8'h45, 40, 40);
    send_frame(TYPE_IPV4, '0, 8'h4F, 16, 40);          // header longer than kept part
    send_frame(TYPE_IPV4, '0, 8'h65, 16, 40);          // wrong version
    send_frame(TYPE_IPV4, '0, 8'h44, 16, 40);          // header length below minimum
    send_frame(16'h86DD, '0, 8'h45, 16, 40);
    send_frame(TYPE_CTAG, TYPE_IPV4, 8'h45, 40, 40);   // header ends on the cut
    send_frame(TYPE_IPV4, '0, 8'h45, 25, 40);          // ends inside the header
    send_frame(TYPE_IPV4, '0, 8'h45, 15, 40);          // ends on the first header byte

    wait_quiet();
    set_config(1'b1, 16'd78);                          // largest header
    send_frame(TYPE_IPV4, '0, 8'h4F, 80, 80);

    while (sent_beats < ItemBudget) begin
      kind = $urandom_range(0, 9);
      ihl  = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 15) : $urandom_range(5, 8);
      ver_ihl = {IPV4_VERSION, 4'(ihl)};
      case ($urandom_range(0, 2))
        0: outer = TYPE_IPV4;
        1: outer = TYPE_CTAG;
        default: outer = TYPE_STAG;
      endcase
      inner  = TYPE_IPV4;
      ip_at  = (outer == TYPE_IPV4) ? 14 : 18;
      nbytes = ip_at + ihl * 4 + $urandom_range(0, 24);
      flen   = 16'(nbytes);
      if (kind == 6) begin
        nbytes = $urandom_range(1, nbytes);
      end else if (kind == 7) begin
        ver_ihl = 8'($urandom);
      end else if (kind == 8) begin
        if ($urandom_range(0, 1) == 0) outer = 16'($urandom);
        inner = 16'($urandom);
      end else if (kind == 9) begin
        outer   = 16'($urandom);
        inner   = 16'($urandom);
        ver_ihl = 8'($urandom);
        nbytes  = $urandom_range(1, 40);
        flen    = 16'($urandom);
      end

      // The tail of the run goes without idling on either side.
      if (sent_beats >= ItemBudget * 3 / 4) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
      end

      if ($urandom_range(0, 1) == 0) begin
        wait_quiet();
        hdr_end = ip_at + ihl * 4;
        case ($urandom_range(0, 9))
          0: keep = 16'd0;
          1: keep = 16'hFFFF;
          2: keep = 16'($urandom_range(1, 33));
          3: keep = 16'($urandom);
          default: keep = 16'($urandom_range(hdr_end - 2, nbytes + 1));
        endcase
        set_config($urandom_range(0, 7) != 0, keep);
      end

      send_frame(outer, inner, ver_ihl, nbytes, flen);
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (beats_owed != 0);
    repeat (SettleWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
